// File: design/pid_controller_clamped_core_assert.svh
// Assertion macros shared by the controller RTL.
`ifndef PID_CONTROLLER_CLAMPED_CORE_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pidc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pidc assertion failed");

`endif

// File: design/pidc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

    localparam logic [1:0] ACT_ERROR = 2'd0;
    localparam logic [1:0] ACT_TRACK = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [2:0] REG_OUTPUT_LOW    = 3'd3;
    localparam logic [2:0] REG_OUTPUT_HIGH   = 3'd4;
    localparam logic [2:0] REG_INTEGRAL_LOW  = 3'd5;
    localparam logic [2:0] REG_INTEGRAL_HIGH = 3'd6;
    localparam logic [2:0] REG_STEP_PERIOD   = 3'd7;

    localparam logic signed [31:0] RST_PROP_GAIN = 32'sh0001_0000;
    localparam logic signed [31:0] RST_ZERO      = 32'sh0000_0000;
    localparam logic signed [31:0] RST_LOW       = 32'sh8000_0000;
    localparam logic signed [31:0] RST_HIGH      = 32'sh7FFF_FFFF;
    localparam logic [31:0]        RST_PERIOD    = 32'd4294967;

    localparam int DIV_STEPS = 47;
    localparam int DERIV_W   = 48;

    localparam logic signed [DERIV_W-1:0] DERIV_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [DERIV_W-1:0] DERIV_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic                      done;
        logic signed [DERIV_W-1:0] deriv;
    } t_div_res;

endpackage

`default_nettype wire

// File: design/pid_controller_clamped_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// in        input      i_in_valid/o_in_ready    i_action, i_target_or_error, i_feedback
// out       output     o_out_valid/i_out_ready  o_control_output
// cfg       input      i_cfg_we                 i_cfg_index, i_cfg_wdata
//
// A run transfer waits on the 47-step restoring divider, which finishes at once when the
// derivative is zero or saturates; its result turns valid in S_FIN once the output is free.
// One shared 33x33 multiplier handles all products.
// Clear transfers and the unused action leave the controller idle and give no result.
// Reset is synchronous and restores the registers and the controller state.
// A finished result waits, with the input not ready, while a previous one stalls.

module pid_controller_clamped_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [31:0] i_target_or_error,
    input  wire logic signed [31:0] i_feedback,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_control_output,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_wdata
);

    `include "pid_controller_clamped_core_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_MPER, S_MKP, S_MKI, S_ADDKI, S_WAITD, S_MKDL, S_ADDDL, S_FIN
    } t_state;

    t_state                r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    logic signed [31:0]    r_out, n_out;
    logic signed [31:0]    r_integ, n_integ;
    logic signed [31:0]    r_prev, n_prev;
    logic signed [31:0]    r_err, n_err;
    logic signed [31:0]    r_tgt, n_tgt;
    logic signed [31:0]    r_fb, n_fb;
    logic [1:0]            r_act, n_act;
    logic signed [65:0]    r_acc, n_acc;
    logic signed [31:0]    r_kp, r_ki, r_kd;
    logic signed [31:0]    r_olo, r_ohi, r_ilo, r_ihi;
    logic [31:0]           r_period;

    logic signed [32:0]    s_ma, s_mb;
    logic signed [65:0]    w_prod;
    logic                  s_div_start;
    logic signed [32:0]    s_diff;
    pidc_pkg::t_div_res    w_div;
    logic signed [32:0]    s_trk;
    logic signed [33:0]    s_isum;
    logic signed [31:0]    s_sat;
    logic                  s_in_xfer;

    pidc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (s_ma),
        .i_b   (s_mb),
        .o_p   (w_prod)
    );

    pidc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (s_div_start),
        .i_diff   (s_diff),
        .i_period (r_period),
        .o_res    (w_div)
    );

    assign o_in_ready       = (r_state == S_IDLE);
    assign s_in_xfer        = i_in_valid && o_in_ready;
    assign o_out_valid      = r_out_valid;
    assign o_control_output = r_out;
    assign s_diff           = {r_err[31], r_err} - {r_prev[31], r_prev};

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_integ     = r_integ;
        n_prev      = r_prev;
        n_err       = r_err;
        n_tgt       = r_tgt;
        n_fb        = r_fb;
        n_act       = r_act;
        n_acc       = r_acc;
        s_ma        = '0;
        s_mb        = '0;
        s_div_start = 1'b0;
        s_trk       = {r_tgt[31], r_tgt} - {r_fb[31], r_fb};
        s_isum      = {{2{r_integ[31]}}, r_integ} + w_prod[65:32];
        if (r_acc > 66'sd2147483647) begin
            s_sat = 32'sh7FFF_FFFF;
        end else if (r_acc < -66'sd2147483648) begin
            s_sat = 32'sh8000_0000;
        end else begin
            s_sat = r_acc[31:0];
        end
        if (o_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (s_in_xfer) begin
                    n_tgt = i_target_or_error;
                    n_fb  = i_feedback;
                    n_act = i_action;
                    if (i_action == pidc_pkg::ACT_CLEAR) begin
                        n_integ = '0;
                        n_prev  = '0;
                    end else if ((i_action == pidc_pkg::ACT_ERROR) ||
                                 (i_action == pidc_pkg::ACT_TRACK)) begin
                        n_state = S_ERR;
                    end
                end
            end
            S_ERR: begin
                if (r_act == pidc_pkg::ACT_TRACK) begin
                    if (s_trk[32] != s_trk[31]) begin
                        n_err = s_trk[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end else begin
                        n_err = s_trk[31:0];
                    end
                end else begin
                    n_err = r_tgt;
                end
                n_state = S_MPER;
            end
            S_MPER: begin
                s_ma        = {r_err[31], r_err};
                s_mb        = {1'b0, r_period};
                s_div_start = 1'b1;
                n_state     = S_MKP;
            end
            S_MKP: begin
                s_ma = {r_kp[31], r_kp};
                s_mb = {r_err[31], r_err};
                if (s_isum > $signed({{2{r_ihi[31]}}, r_ihi})) begin
                    n_integ = r_ihi;
                end else if (s_isum < $signed({{2{r_ilo[31]}}, r_ilo})) begin
                    n_integ = r_ilo;
                end else begin
                    n_integ = s_isum[31:0];
                end
                n_state = S_MKI;
            end
            S_MKI: begin
                s_ma    = {r_ki[31], r_ki};
                s_mb    = {r_integ[31], r_integ};
                n_acc   = w_prod >>> 16;
                n_state = S_ADDKI;
            end
            S_ADDKI: begin
                n_acc   = r_acc + (w_prod >>> 16);
                n_state = S_WAITD;
            end
            S_WAITD: begin
                s_ma = {r_kd[31], r_kd};
                s_mb = {w_div.deriv[47], w_div.deriv[47:16]};
                if (w_div.done) begin
                    n_state = S_MKDL;
                end
            end
            S_MKDL: begin
                s_ma    = {r_kd[31], r_kd};
                s_mb    = {17'd0, w_div.deriv[15:0]};
                n_acc   = r_acc + w_prod;
                n_state = S_ADDDL;
            end
            S_ADDDL: begin
                n_acc   = r_acc + (w_prod >>> 16);
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    if (s_sat > r_ohi) begin
                        n_out = r_ohi;
                    end else if (s_sat < r_olo) begin
                        n_out = r_olo;
                    end else begin
                        n_out = s_sat;
                    end
                    n_out_valid = 1'b1;
                    n_prev      = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_prev      <= '0;
            r_kp        <= pidc_pkg::RST_PROP_GAIN;
            r_ki        <= pidc_pkg::RST_ZERO;
            r_kd        <= pidc_pkg::RST_ZERO;
            r_olo       <= pidc_pkg::RST_LOW;
            r_ohi       <= pidc_pkg::RST_HIGH;
            r_ilo       <= pidc_pkg::RST_LOW;
            r_ihi       <= pidc_pkg::RST_HIGH;
            r_period    <= pidc_pkg::RST_PERIOD;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_integ     <= n_integ;
            r_prev      <= n_prev;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pidc_pkg::REG_PROP_GAIN:     r_kp     <= i_cfg_wdata;
                    pidc_pkg::REG_INTEG_GAIN:    r_ki     <= i_cfg_wdata;
                    pidc_pkg::REG_DERIV_GAIN:    r_kd     <= i_cfg_wdata;
                    pidc_pkg::REG_OUTPUT_LOW:    r_olo    <= i_cfg_wdata;
                    pidc_pkg::REG_OUTPUT_HIGH:   r_ohi    <= i_cfg_wdata;
                    pidc_pkg::REG_INTEGRAL_LOW:  r_ilo    <= i_cfg_wdata;
                    pidc_pkg::REG_INTEGRAL_HIGH: r_ihi    <= i_cfg_wdata;
                    pidc_pkg::REG_STEP_PERIOD:   r_period <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        r_out <= n_out;
        r_err <= n_err;
        r_tgt <= n_tgt;
        r_fb  <= n_fb;
        r_act <= n_act;
        r_acc <= n_acc;
    end

    `PIDC_ASSERT_NEXT(a_clear_zeroes, i_clk, i_rst_n,
        s_in_xfer && (i_action == pidc_pkg::ACT_CLEAR), (r_integ == 0) && (r_prev == 0))
    `PIDC_ASSERT_NOW(a_div_done_before_use, i_clk, i_rst_n,
        (r_state == S_MKDL) || (r_state == S_ADDDL), w_div.done)
    `PIDC_ASSERT_NEXT(a_fin_waits_on_stall, i_clk, i_rst_n,
        (r_state == S_FIN) && r_out_valid && !i_out_ready, r_state == S_FIN)
    `PIDC_ASSERT_NEXT(a_out_held, i_clk, i_rst_n,
        o_out_valid && !i_out_ready, o_out_valid && $stable(o_control_output))

endmodule

`default_nettype wire

// File: design/pidc_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module pidc_mul (
    input  wire logic               i_clk,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [32:0] i_b,
    output logic signed [65:0]      o_p
);

    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// File: design/pidc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pidc_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [32:0] i_diff,
    input  wire logic [31:0]        i_period,
    output pidc_pkg::t_div_res      o_res
);

    localparam int CNT_W = $clog2(pidc_pkg::DIV_STEPS);
    localparam int WRK_W = pidc_pkg::DIV_STEPS;

    typedef enum logic {D_IDLE, D_RUN} t_dstate;

    t_dstate                           r_state, n_state;
    logic                              r_done, n_done;
    logic                              r_neg, n_neg;
    logic [31:0]                       r_rem, n_rem;
    logic [WRK_W-1:0]                  r_work, n_work;
    logic [CNT_W-1:0]                  r_cnt, n_cnt;
    logic signed [pidc_pkg::DERIV_W-1:0] r_deriv, n_deriv;

    logic signed [32:0] s_mag33;
    logic [31:0]        s_mag;
    logic [32:0]        s_trial;
    logic               s_ge;

    always_comb begin
        n_state = r_state;
        n_done  = r_done;
        n_neg   = r_neg;
        n_rem   = r_rem;
        n_work  = r_work;
        n_cnt   = r_cnt;
        n_deriv = r_deriv;
        s_mag33 = i_diff[32] ? -i_diff : i_diff;
        s_mag   = s_mag33[31:0];
        s_trial = {r_rem, r_work[WRK_W-1]};
        s_ge    = s_trial >= {1'b0, i_period};
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_neg = i_diff[32];
                    if (s_mag == 32'd0) begin
                        n_deriv = '0;
                        n_done  = 1'b1;
                    end else if ((i_period == 32'd0) ||
                                 ({15'd0, s_mag} >= {i_period, 15'd0})) begin
                        n_deriv = i_diff[32] ? pidc_pkg::DERIV_MIN : pidc_pkg::DERIV_MAX;
                        n_done  = 1'b1;
                    end else begin
                        n_rem   = {15'd0, s_mag[31:15]};
                        n_work  = {s_mag[14:0], 32'd0};
                        n_cnt   = '0;
                        n_done  = 1'b0;
                        n_state = D_RUN;
                    end
                end
            end
            D_RUN: begin
                n_rem  = s_ge ? 32'(s_trial - {1'b0, i_period}) : s_trial[31:0];
                n_work = {r_work[WRK_W-2:0], s_ge};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(pidc_pkg::DIV_STEPS - 1)) begin
                    n_deriv = r_neg ? -$signed({1'b0, n_work}) : $signed({1'b0, n_work});
                    n_done  = 1'b1;
                    n_state = D_IDLE;
                end
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_neg   <= n_neg;
        r_rem   <= n_rem;
        r_work  <= n_work;
        r_cnt   <= n_cnt;
        r_deriv <= n_deriv;
    end

    assign o_res = {r_done, r_deriv};

endmodule

`default_nettype wire
